// ----- rtl/fkp_pkg.sv -----
// Shared types, constants and the FNV-1a step for the keyed linear-probe table.
// Used by fkp_ctrl, fkp_datapath, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package fkp_pkg;

   // Table geometry
   localparam int MAX_BUCKETS = 1024;
   localparam int BKT_ADDR_W  = $clog2(MAX_BUCKETS);
   localparam int CNT_W       = BKT_ADDR_W + 1;

   // Request and response field widths
   localparam int BYTE_W   = 8;
   localparam int HASH_W   = 64;
   localparam int ENTRY_W  = 10;
   localparam int STATUS_W = 2;

   // Configuration register
   localparam int LOG2_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(BKT_ADDR_W);

   // FNV-1a 64 constants; the prime is 2^40 + 0x1b3
   localparam logic [HASH_W-1:0] FNV_BASIS       = 64'hcbf29ce484222325;
   localparam logic [8:0]        FNV_PRIME_LOW   = 9'h1b3;
   localparam int                FNV_PRIME_SHIFT = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUCKET_LOG2 = '0
   } csr_index_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED   = 2'd0,
      STATUS_FOUND      = 2'd1,
      STATUS_NOT_FOUND  = 2'd2,
      STATUS_TABLE_FULL = 2'd3
   } status_type;

   // One bucket: a valid flag and the entry index it points to.
   typedef struct packed {
      logic                  valid;
      logic [BKT_ADDR_W-1:0] index;
   } bucket_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       start;
      logic       advance;
      logic       commit_insert;
      logic       set_result;
      status_type result_status;
      logic       clear_step;
      logic       rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cfg_write;
      logic is_lookup;
      logic insert_full;
      logic bucket_valid;
      logic hash_match;
      logic sweep_last;
      logic clear_last;
   } dp_status_type;

   // One FNV-1a step: xor the byte in, then multiply by the prime as a
   // shift plus a narrow 64 x 9 product.
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      logic [HASH_W-1:0] low_prod;
      x        = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
      low_prod = HASH_W'(x * FNV_PRIME_LOW);
      return (x << FNV_PRIME_SHIFT) + low_prod;
   endfunction

endpackage

// ----- rtl/fkp_datapath.sv -----
// Datapath of the keyed linear-probe table: running hash, bucket and entry memories,
// probe pointer, entry count, configuration register and response registers.
// Depends on fkp_pkg.
`timescale 1ns / 1ps

module fkp_datapath import fkp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             stat,
   input  logic                      req_func,
   input  logic [BYTE_W-1:0]         req_key_byte,
   input  logic                      req_last_byte,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ENTRY_W-1:0]        rsp_entry_index,
   output logic [HASH_W-1:0]         rsp_key_hash
);

   // Control state
   logic [HASH_W-1:0]     run_hash_ff, run_hash_in;
   logic [CNT_W-1:0]      count_ff;
   logic [LOG2_W-1:0]     lg_ff;
   logic [BKT_ADDR_W-1:0] clear_addr_ff;

   // Payload registers
   logic [HASH_W-1:0]     key_hash_ff;
   logic                  func_ff;
   logic [BKT_ADDR_W-1:0] slot_ff;
   logic [CNT_W-1:0]      probe_cnt_ff;
   bucket_type            bkt_rd_ff;
   logic [HASH_W-1:0]     ent_rd_ff;
   status_type            result_status_ff;
   logic [BKT_ADDR_W-1:0] result_index_ff;
   status_type            rsp_status_ff;
   logic [BKT_ADDR_W-1:0] rsp_index_ff;
   logic [HASH_W-1:0]     rsp_hash_ff;

   // Memories
   bucket_type            bkt_mem [MAX_BUCKETS];
   logic [HASH_W-1:0]     ent_mem [MAX_BUCKETS];

   logic                  cfg_write;
   logic [LOG2_W-1:0]     lg_sat;
   logic [CNT_W-1:0]      bucket_n;
   logic [BKT_ADDR_W-1:0] mask;
   logic [HASH_W-1:0]     remapped;

   // Register write decode; low address bits select bytes and are ignored.
   assign cfg_write = psel & penable & pwrite
                    & (paddr[CSR_ADDR_W-1:2] == CSR_BUCKET_LOG2);

   always_comb begin
      if (paddr[CSR_ADDR_W-1:2] == CSR_BUCKET_LOG2) begin
         prdata = {{(CSR_DATA_W-LOG2_W){1'b0}}, lg_ff};
      end else begin
         prdata = '0;
      end
   end

   // Buckets in use, saturated at the table size.
   assign lg_sat   = (lg_ff > LOG2_MAX) ? LOG2_MAX : lg_ff;
   assign bucket_n = CNT_W'(1) << lg_sat;
   assign mask     = BKT_ADDR_W'(bucket_n - CNT_W'(1));

   // A final hash of zero is reported as one.
   assign remapped    = (key_hash_ff == '0) ? HASH_W'(1) : key_hash_ff;
   assign run_hash_in = fnv_step(run_hash_ff, req_key_byte);

   // Status toward the controller
   always_comb begin
      stat.cfg_write    = cfg_write;
      stat.is_lookup    = (func_ff == FUNC_LOOKUP);
      stat.insert_full  = (count_ff >= bucket_n);
      stat.bucket_valid = bkt_rd_ff.valid;
      stat.hash_match   = (ent_rd_ff == key_hash_ff);
      stat.sweep_last   = (probe_cnt_ff == bucket_n - CNT_W'(1));
      stat.clear_last   = (clear_addr_ff == {BKT_ADDR_W{1'b1}});
   end

   // Running hash, configuration, entry count and clear pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_hash_ff   <= FNV_BASIS;
         count_ff      <= '0;
         lg_ff         <= LOG2_MAX;
         clear_addr_ff <= '0;
      end else begin
         if (cmd.accept) begin
            run_hash_ff <= req_last_byte ? FNV_BASIS : run_hash_in;
         end
         if (cfg_write) begin
            lg_ff         <= pwdata[LOG2_W-1:0];
            count_ff      <= '0;
            clear_addr_ff <= '0;
         end else begin
            if (cmd.commit_insert) begin
               count_ff <= count_ff + CNT_W'(1);
            end
            if (cmd.clear_step) begin
               clear_addr_ff <= clear_addr_ff + BKT_ADDR_W'(1);
            end
         end
      end
   end

   // Key capture, probe pointer and result registers.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_last_byte) begin
         key_hash_ff <= run_hash_in;
         func_ff     <= req_func;
      end
      if (cmd.start) begin
         key_hash_ff  <= remapped;
         slot_ff      <= remapped[BKT_ADDR_W-1:0] & mask;
         probe_cnt_ff <= '0;
      end else if (cmd.advance) begin
         slot_ff      <= (slot_ff + BKT_ADDR_W'(1)) & mask;
         probe_cnt_ff <= probe_cnt_ff + CNT_W'(1);
      end
      if (cmd.commit_insert) begin
         result_status_ff <= STATUS_INSERTED;
         result_index_ff  <= count_ff[BKT_ADDR_W-1:0];
      end else if (cmd.set_result) begin
         result_status_ff <= cmd.result_status;
         result_index_ff  <= (cmd.result_status == STATUS_FOUND) ? bkt_rd_ff.index : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= result_status_ff;
         rsp_index_ff  <= result_index_ff;
         rsp_hash_ff   <= key_hash_ff;
      end
   end

   // Bucket memory: one write port shared by the clearing pass and inserts,
   // one registered read at the probe pointer.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         bkt_mem[clear_addr_ff] <= '0;
      end else if (cmd.commit_insert) begin
         bkt_mem[slot_ff] <= '{valid: 1'b1, index: count_ff[BKT_ADDR_W-1:0]};
      end
      bkt_rd_ff <= bkt_mem[slot_ff];
   end

   // Entry hash memory: written at the entry count, read at the bucket's index.
   always_ff @(posedge clock) begin
      if (cmd.commit_insert) begin
         ent_mem[count_ff[BKT_ADDR_W-1:0]] <= key_hash_ff;
      end
      ent_rd_ff <= ent_mem[bkt_rd_ff.index];
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = ENTRY_W'(rsp_index_ff);
   assign rsp_key_hash    = rsp_hash_ff;

endmodule

// ----- rtl/fkp_ctrl.sv -----
// Controller of the keyed linear-probe table: sequences hashing, probing,
// the clearing pass and the response handshake. Depends on fkp_pkg.
`timescale 1ns / 1ps

module fkp_ctrl import fkp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_last_byte,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_BKT_RD,
      S_BKT_CHK,
      S_ENT_CHK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      cmd           = '0;
      cmd.result_status = STATUS_NOT_FOUND;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last_byte) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (!stat.is_lookup && stat.insert_full) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = STATUS_TABLE_FULL;
               state_in          = S_RESP;
            end else begin
               state_in = S_BKT_RD;
            end
         end
         S_BKT_RD: begin
            state_in = S_BKT_CHK;
         end
         S_BKT_CHK: begin
            if (!stat.bucket_valid) begin
               // Empty bucket ends the probe either way.
               if (stat.is_lookup) begin
                  cmd.set_result    = 1'b1;
                  cmd.result_status = STATUS_NOT_FOUND;
               end else begin
                  cmd.commit_insert = 1'b1;
               end
               state_in = S_RESP;
            end else if (stat.is_lookup) begin
               state_in = S_ENT_CHK;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_BKT_RD;
            end
         end
         S_ENT_CHK: begin
            if (stat.hash_match) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = STATUS_FOUND;
               state_in          = S_RESP;
            end else if (stat.sweep_last) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = STATUS_NOT_FOUND;
               state_in          = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_BKT_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // A register write empties the table through a fresh clearing pass.
      if (stat.cfg_write) begin
         state_in = S_CLEAR;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/fnv_keyed_linear_probe_table.sv -----
// Keyed linear-probe hash table: FNV-1a 64 key hashing and an open-addressing bucket table.
// Non-last bytes are taken back to back. A last byte starts a probe: start, then bucket read
// and bucket check per bucket probed (a lookup also checks a valid bucket's entry), then the
// response state, which waits out a stalled earlier response; a full-table insert skips the
// probe. A new request can be taken in the cycle after the response is loaded. Synchronous
// reset and bucket_count_log2 writes start a 1024-bucket clearing pass that blocks requests.
`timescale 1ns / 1ps

module fnv_keyed_linear_probe_table import fkp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [BYTE_W-1:0]     req_key_byte,
   input  logic                  req_last_byte,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ENTRY_W-1:0]    rsp_entry_index,
   output logic [HASH_W-1:0]     rsp_key_hash,
   // Configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   // The register port never stalls.
   assign pready = 1'b1;

   // Sequencer
   fkp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Hashing, memories and result registers
   fkp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_key_byte    (req_key_byte),
      .req_last_byte   (req_last_byte),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_key_hash    (rsp_key_hash)
   );

endmodule

// ----- rtl/fkp_checker.sv -----
// Port-level checker for the keyed linear-probe table, bound to the top level.
// Depends on fkp_pkg and fnv_keyed_linear_probe_table.
`timescale 1ns / 1ps

module fkp_checker import fkp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_byte,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [ENTRY_W-1:0]    rsp_entry_index,
   input logic [HASH_W-1:0]     rsp_key_hash,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr
);

   // A stalled response holds its hash.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_hash))
      else $error("response changed while stalled");

   // A reported hash is never zero.
   hash_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_hash != '0)
      else $error("zero hash reported");

   // Not found and table full carry index zero.
   index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_TABLE_FULL)
      |-> rsp_entry_index == '0)
      else $error("nonzero index on miss or full");

   // A last byte starts a probe, so no request is taken in the next cycle.
   busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> !req_ready)
      else $error("request taken during probe");

   // A register write starts the clearing pass.
   busy_after_cfg: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[CSR_ADDR_W-1:2] == CSR_BUCKET_LOG2 |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind fnv_keyed_linear_probe_table fkp_checker u_fkp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_byte   (req_last_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_entry_index (rsp_entry_index),
   .rsp_key_hash    (rsp_key_hash),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .paddr           (paddr)
);

// ----- tb/sv/fkp_checker.sv -----
// Response checker for the keyed linear-probe table: tracks the hash, entry and bucket state.
// It watches the request, response and configuration ports and predicts every response.
// Depends on fkp_pkg for field widths, enums and the FNV offset basis.
`timescale 1ns / 1ps

module fkp_resp_checker import fkp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_func,
   input  logic [BYTE_W-1:0]     req_key_byte,
   input  logic                  req_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [ENTRY_W-1:0]    rsp_entry_index,
   input  logic [HASH_W-1:0]     rsp_key_hash,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    error_count,
   output int                    pending_count,
   output int                    response_count,
   output int                    found_count,
   output int                    full_count
);

   typedef struct packed {
      status_type         status;
      logic [ENTRY_W-1:0] index;
      logic [HASH_W-1:0]  hash;
   } probe_result_type;

   // Local copy of the table state.
   logic [HASH_W-1:0] hash_acc;
   logic [HASH_W-1:0] entry_hash [MAX_BUCKETS];
   bucket_type        bucket [MAX_BUCKETS];
   logic [CNT_W-1:0]  n_entries;
   logic [LOG2_W-1:0] log2_reg;
   probe_result_type  expected_q [$];

   initial begin
      error_count    = 0;
      pending_count  = 0;
      response_count = 0;
      found_count    = 0;
      full_count     = 0;
   end

   task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                  input logic [HASH_W-1:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic empty_buckets();
      for (int i = 0; i < MAX_BUCKETS; i++)
         bucket[i] = '0;
      n_entries = '0;
   endtask

   // Walk the bucket table from the home slot of the finished key hash.
   task automatic probe_buckets(input func_type op, input logic [HASH_W-1:0] h,
                                output probe_result_type res);
      int n;
      int mask;
      int slot;
      n    = (log2_reg > LOG2_MAX) ? MAX_BUCKETS : (1 << log2_reg);
      mask = n - 1;
      slot = int'(h[BKT_ADDR_W-1:0]) & mask;
      res.status = STATUS_NOT_FOUND;
      res.index  = '0;
      res.hash   = h;
      if (op == FUNC_INSERT) begin
         if (int'(n_entries) >= n) begin
            // No room: nothing is stored.
            res.status = STATUS_TABLE_FULL;
         end else begin
            for (int p = 0; p < n; p++) begin
               if (!bucket[slot].valid)
                  break;
               slot = (slot + 1) & mask;
            end
            entry_hash[n_entries[BKT_ADDR_W-1:0]] = h;
            bucket[slot].valid = 1'b1;
            bucket[slot].index = n_entries[BKT_ADDR_W-1:0];
            res.status = STATUS_INSERTED;
            res.index  = n_entries[ENTRY_W-1:0];
            n_entries++;
         end
      end else begin
         // Stop at an empty bucket, a matching entry, or after one full sweep.
         for (int p = 0; p < n; p++) begin
            if (!bucket[slot].valid)
               break;
            if (entry_hash[bucket[slot].index] == h) begin
               res.status = STATUS_FOUND;
               res.index  = bucket[slot].index;
               break;
            end
            slot = (slot + 1) & mask;
         end
      end
   endtask

   always @(posedge clock) begin
      probe_result_type want;
      probe_result_type got;
      logic [HASH_W-1:0] fin;
      if (reset) begin
         hash_acc = FNV_BASIS;
         log2_reg = LOG2_MAX;
         empty_buckets();
         expected_q.delete();
      end else begin
         // Responses first: a response leaving now belongs to an older request.
         if (rsp_valid && rsp_ready) begin
            response_count++;
            if (expected_q.size() == 0) begin
               $display("[%0t] response with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", HASH_W'(rsp_status), HASH_W'(want.status));
               if (rsp_entry_index != want.index)
                  report_mismatch("entry_index", HASH_W'(rsp_entry_index), HASH_W'(want.index));
               if (rsp_key_hash != want.hash)
                  report_mismatch("key_hash", rsp_key_hash, want.hash);
               if (want.status == STATUS_FOUND)
                  found_count++;
               if (want.status == STATUS_TABLE_FULL)
                  full_count++;
            end
         end

         // Fold the request byte into the running hash; a last byte finishes the key.
         if (req_valid && req_ready) begin
            hash_acc = (hash_acc ^ HASH_W'(req_key_byte)) * 64'h0000_0100_0000_01b3;
            if (req_last_byte) begin
               fin      = (hash_acc == '0) ? HASH_W'(1) : hash_acc;
               hash_acc = FNV_BASIS;
               probe_buckets(func_type'(req_func), fin, got);
               expected_q = {expected_q, got};
            end
         end

         // Register access: a write empties the table, a read must return the register.
         if (psel && penable && pready &&
             paddr[CSR_ADDR_W-1:2] == CSR_BUCKET_LOG2) begin
            if (pwrite) begin
               log2_reg = pwdata[LOG2_W-1:0];
               empty_buckets();
            end else if (prdata != CSR_DATA_W'(log2_reg)) begin
               report_mismatch("bucket_count_log2 read", HASH_W'(prdata), HASH_W'(log2_reg));
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the keyed linear-probe table testbench: clock, reset, stimulus and verdict.
// Instantiates fnv_keyed_linear_probe_table and fkp_resp_checker; uses fkp_pkg.
`timescale 1ns / 1ps

module tb_top import fkp_pkg::*; ();

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int END_CYCLES   = 64;
   localparam int PHASE_BYTES  = 48;

   // A key of one to eight bytes; the first byte sits in the low bits.
   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] bytes;
   } key_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_func = 1'b0;
   logic [BYTE_W-1:0]     req_key_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ENTRY_W-1:0]    rsp_entry_index;
   logic [HASH_W-1:0]     rsp_key_hash;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int error_count;
   int pending_count;
   int response_count;
   int found_count;
   int full_count;
   int cycle_count = 0;
   int bytes_sent = 0;
   int phase_count = 0;
   logic no_idle = 1'b0;
   key_type key_pool [$];

   fnv_keyed_linear_probe_table u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_key_byte, .req_last_byte,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_entry_index, .rsp_key_hash,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   fkp_resp_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_key_byte, .req_last_byte,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_entry_index, .rsp_key_hash,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .error_count, .pending_count, .response_count, .found_count, .full_count
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // The response side stalls at random except during the calm stretch.
   always @(negedge clock)
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 34);

   // Offer one request byte, with random idle cycles ahead of it.
   task automatic send_byte(input logic func, input logic [BYTE_W-1:0] data,
                            input logic last);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 34) begin
         req_valid     <= 1'b0;
         req_func      <= 1'($urandom);
         req_key_byte  <= BYTE_W'($urandom);
         req_last_byte <= 1'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_key_byte  <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Send a whole key; the operation only matters on the last byte.
   task automatic send_key(input func_type op, input key_type k);
      for (int i = 0; i < k.len; i++) begin
         if (i == k.len - 1)
            send_byte(op, k.bytes[8*i +: 8], 1'b1);
         else
            send_byte(1'($urandom), k.bytes[8*i +: 8], 1'b0);
      end
   endtask

   function automatic key_type random_key();
      key_type k;
      k.len   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 8))
                                            : 4'($urandom_range(1, 4));
      k.bytes = {$urandom, $urandom};
      return k;
   endfunction

   function automatic key_type short_key(input logic [31:0] bytes, input int len);
      key_type k;
      k.len   = 4'(len);
      k.bytes = 64'(bytes);
      return k;
   endfunction

   // Let every outstanding response come back, then leave the block quiet for DRAIN_CYCLES.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [LOG2_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {CSR_BUCKET_LOG2, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Resize the table (which empties it) and read the setting back.
   task automatic new_table(input logic [LOG2_W-1:0] log2);
      wait_idle();
      csr_access(1'b1, log2);
      csr_access(1'b0, '0);
      key_pool.delete();
      phase_count++;
   endtask

   // Random keys: mostly fresh inserts and lookups of stored keys, plus misses and duplicates.
   task automatic random_phase(input logic [LOG2_W-1:0] log2);
      int stop_at;
      int pick;
      key_type k;
      new_table(log2);
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (key_pool.size() == 0 || pick < 40) begin
            k = random_key();
            key_pool = {key_pool, k};
            send_key(FUNC_INSERT, k);
         end else if (pick < 70) begin
            send_key(FUNC_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
         end else if (pick < 88) begin
            send_key(FUNC_LOOKUP, random_key());
         end else begin
            send_key(FUNC_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
         end
      end
   endtask

   initial begin
      logic [LOG2_W-1:0] sizes [10];
      sizes = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd10,
                4'd4, 4'd12, 4'd5, 4'd11, 4'd2};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // One bucket: fill it, then insert into the full table and sweep it on a miss.
      new_table(4'd0);
      send_key(FUNC_INSERT, short_key(32'h00, 1));
      send_key(FUNC_INSERT, short_key(32'hff, 1));
      send_key(FUNC_LOOKUP, short_key(32'h00, 1));
      send_key(FUNC_LOOKUP, short_key(32'hff, 1));

      // Out-of-range size saturates to the largest table.
      new_table(4'd15);
      send_key(FUNC_LOOKUP, short_key(32'h5a, 1));
      send_key(FUNC_INSERT, short_key(32'h00, 1));
      send_key(FUNC_INSERT, short_key(32'h00, 1));
      send_key(FUNC_LOOKUP, short_key(32'h00, 1));
      send_key(FUNC_INSERT, short_key(32'h7f80_00ff, 4));
      send_key(FUNC_LOOKUP, short_key(32'h7f80_00ff, 4));
      send_key(FUNC_LOOKUP, short_key(32'h7f80_00fe, 4));

      // Random traffic over a range of table sizes; one phase runs without idling.
      foreach (sizes[i]) begin
         no_idle = (i == 3);
         random_phase(sizes[i]);
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (END_CYCLES) @(negedge clock);
      $display("Sent %0d request bytes over %0d table settings in %0d cycles.",
               bytes_sent, phase_count, cycle_count);
      $display("Checked %0d responses: %0d lookups found, %0d inserts into a full table.",
               response_count, found_count, full_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fkp_pkg.sv
rtl/fkp_datapath.sv
rtl/fkp_ctrl.sv
rtl/fnv_keyed_linear_probe_table.sv
rtl/fkp_checker.sv
tb/sv/fkp_checker.sv
tb/sv/tb_top.sv
